/* sv/sbq_pkg.sv */
// Shared types and constants for the stereo biquad peaking filter.
// No dependencies; imported by every module of the block.
package sbq_pkg;

  localparam int ACC_W       = 64;
  localparam int NUM_COEF    = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QLVL_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0     = 3'd0,
    CFG_B1     = 3'd1,
    CFG_B2     = 3'd2,
    CFG_A1     = 3'd3,
    CFG_A2     = 3'd4,
    CFG_ENABLE = 3'd5
  } cfg_reg_e;

  // Bypass items carry the raw samples in the low bits of the sums.
  typedef struct packed {
    logic             bypass;
    logic [ACC_W-1:0] left_sum;
    logic [ACC_W-1:0] right_sum;
  } sbq_item_t;

  typedef struct packed {
    logic              empty;
    logic [QLVL_W-1:0] level;
  } sbq_qstat_t;

endpackage

/* sv/sbq_cfg.sv */
// Coefficient and enable registers with their write channel.
// Depends on sbq_pkg.
module sbq_cfg #(
  parameter int COEF_WIDTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  logic [sbq_pkg::CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [COEF_WIDTH-1:0]                        cfg_data_i,
  output logic [sbq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0] coef_o,
  output logic                                         enable_o
);
  import sbq_pkg::*;

  localparam logic [NUM_COEF-1:0][COEF_WIDTH-1:0] COEF_RST =
    (NUM_COEF*COEF_WIDTH)'(1) << (COEF_WIDTH - 5);

  logic [NUM_COEF-1:0][COEF_WIDTH-1:0] coef_q, coef_d;
  logic                                enable_q, enable_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    coef_d   = coef_q;
    enable_d = enable_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_B0:     coef_d[CFG_B0] = cfg_data_i;
        CFG_B1:     coef_d[CFG_B1] = cfg_data_i;
        CFG_B2:     coef_d[CFG_B2] = cfg_data_i;
        CFG_A1:     coef_d[CFG_A1] = cfg_data_i;
        CFG_A2:     coef_d[CFG_A2] = cfg_data_i;
        CFG_ENABLE: enable_d = cfg_data_i[0];
        default:    enable_d = enable_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= COEF_RST;
      enable_q <= 1'b1;
    end else begin
      coef_q   <= coef_d;
      enable_q <= enable_d;
    end
  end

  assign coef_o   = coef_q;
  assign enable_o = enable_q;

endmodule

/* sv/sbq_front.sv */
// Front end: accepts frames, keeps input history, forms feedforward sums.
// Depends on sbq_pkg; feeds sbq_queue.
module sbq_front #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]                      left_i,
  input  logic [SAMPLE_WIDTH-1:0]                      right_i,
  input  logic [sbq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0] coef_i,
  input  logic                                         enable_i,
  input  sbq_pkg::sbq_qstat_t                          qstat_i,
  output logic                                         push_o,
  output sbq_pkg::sbq_item_t                           item_o
);
  import sbq_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (COEF_WIDTH - 6);

  logic                           accept;
  logic signed [SAMPLE_WIDTH-1:0] x_in [2];
  logic signed [SAMPLE_WIDTH-1:0] x1_q [2];
  logic signed [SAMPLE_WIDTH-1:0] x2_q [2];
  logic signed [PROD_W-1:0]       p0_d [2];
  logic signed [PROD_W-1:0]       p1_d [2];
  logic signed [PROD_W-1:0]       p2_d [2];
  logic signed [PROD_W-1:0]       p0_q [2];
  logic signed [PROD_W-1:0]       p1_q [2];
  logic signed [PROD_W-1:0]       p2_q [2];
  logic [SAMPLE_WIDTH-1:0]        raw1_q [2];
  logic                           v1_q, v2_q, byp1_q;
  logic [ACC_W-1:0]               sum_d [2];
  sbq_item_t                      item2_q, item2_d;
  logic [QLVL_W-1:0]              credit;

  assign x_in[0] = $signed(left_i);
  assign x_in[1] = $signed(right_i);

  assign credit     = qstat_i.level + {{(QLVL_W-1){1'b0}}, v1_q}
                    + {{(QLVL_W-1){1'b0}}, v2_q};
  assign in_ready_o = credit < QLVL_W'(QUEUE_DEPTH);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      p0_d[ch] = $signed(coef_i[CFG_B0]) * x_in[ch];
      p1_d[ch] = $signed(coef_i[CFG_B1]) * x1_q[ch];
      p2_d[ch] = $signed(coef_i[CFG_B2]) * x2_q[ch];
      sum_d[ch] = ACC_W'(p0_q[ch]) + ACC_W'(p1_q[ch]) + ACC_W'(p2_q[ch]) + ROUND;
    end
  end

  always_comb begin
    item2_d.bypass = byp1_q;
    if (byp1_q) begin
      item2_d.left_sum  = ACC_W'(raw1_q[0]);
      item2_d.right_sum = ACC_W'(raw1_q[1]);
    end else begin
      item2_d.left_sum  = sum_d[0];
      item2_d.right_sum = sum_d[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int ch = 0; ch < 2; ch++) begin
        x1_q[ch] <= '0;
        x2_q[ch] <= '0;
      end
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      if (accept && enable_i) begin
        for (int ch = 0; ch < 2; ch++) begin
          x1_q[ch] <= x_in[ch];
          x2_q[ch] <= x1_q[ch];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byp1_q    <= ~enable_i;
      raw1_q[0] <= left_i;
      raw1_q[1] <= right_i;
      for (int ch = 0; ch < 2; ch++) begin
        p0_q[ch] <= p0_d[ch];
        p1_q[ch] <= p1_d[ch];
        p2_q[ch] <= p2_d[ch];
      end
    end
    if (v1_q) begin
      item2_q <= item2_d;
    end
  end

  assign push_o = v2_q;
  assign item_o = item2_q;

endmodule

/* sv/sbq_queue.sv */
// Short queue between the front end and the feedback stage.
// Depends on sbq_pkg.
module sbq_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sbq_pkg::sbq_item_t  item_i,
  input  logic                pop_i,
  output sbq_pkg::sbq_item_t  item_o,
  output sbq_pkg::sbq_qstat_t qstat_o
);
  import sbq_pkg::*;

  sbq_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLVL_W-1:0] level_q, level_d;

  always_comb begin
    level_d = level_q;
    case ({push_i, pop_i})
      2'b10:   level_d = level_q + QLVL_W'(1);
      2'b01:   level_d = level_q - QLVL_W'(1);
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      level_q <= level_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  assign item_o        = mem_q[rd_ptr_q];
  assign qstat_o.level = level_q;
  assign qstat_o.empty = (level_q == '0);

endmodule

/* sv/sbq_back.sv */
// Back end: feedback taps, rounding, saturation, output history and register.
// Depends on sbq_pkg; drains sbq_queue.
module sbq_back #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  sbq_pkg::sbq_qstat_t                          qstat_i,
  input  sbq_pkg::sbq_item_t                           item_i,
  output logic                                         pop_o,
  input  logic [sbq_pkg::NUM_COEF-1:0][COEF_WIDTH-1:0] coef_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]                      left_o,
  output logic [SAMPLE_WIDTH-1:0]                      right_o
);
  import sbq_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int FRAC   = COEF_WIDTH - 5;
  localparam logic signed [ACC_W-1:0] LIM_HI = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI - ACC_W'(1);

  logic                           upd;
  logic signed [SAMPLE_WIDTH-1:0] y1_q [2];
  logic signed [SAMPLE_WIDTH-1:0] y2_q [2];
  logic [ACC_W-1:0]               fb2_q [2];
  logic [ACC_W-1:0]               fb2_d [2];
  logic signed [PROD_W-1:0]       pa1 [2];
  logic signed [PROD_W-1:0]       pa2 [2];
  logic [ACC_W-1:0]               ff [2];
  logic [ACC_W-1:0]               acc [2];
  logic signed [ACC_W-1:0]        shr [2];
  logic signed [SAMPLE_WIDTH-1:0] y_d [2];
  logic [SAMPLE_WIDTH-1:0]        res_d [2];
  logic                           out_valid_q;
  logic [SAMPLE_WIDTH-1:0]        res_q [2];

  assign pop_o = ~qstat_i.empty & (~out_valid_q | out_ready_i);
  assign upd   = pop_o & ~item_i.bypass;

  assign ff[0] = item_i.left_sum;
  assign ff[1] = item_i.right_sum;

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      pa1[ch] = $signed(coef_i[CFG_A1]) * y1_q[ch];
      pa2[ch] = $signed(coef_i[CFG_A2]) * (upd ? y1_q[ch] : y2_q[ch]);
      fb2_d[ch] = ACC_W'(pa2[ch]);
      acc[ch] = ff[ch] - ACC_W'(pa1[ch]) - fb2_q[ch];
      shr[ch] = $signed(acc[ch]) >>> FRAC;
      if (shr[ch] > LIM_HI) begin
        y_d[ch] = LIM_HI[SAMPLE_WIDTH-1:0];
      end else if (shr[ch] < LIM_LO) begin
        y_d[ch] = LIM_LO[SAMPLE_WIDTH-1:0];
      end else begin
        y_d[ch] = shr[ch][SAMPLE_WIDTH-1:0];
      end
      res_d[ch] = item_i.bypass ? ff[ch][SAMPLE_WIDTH-1:0] : y_d[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int ch = 0; ch < 2; ch++) begin
        y1_q[ch]  <= '0;
        y2_q[ch]  <= '0;
        fb2_q[ch] <= '0;
      end
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      for (int ch = 0; ch < 2; ch++) begin
        fb2_q[ch] <= fb2_d[ch];
        if (upd) begin
          y1_q[ch] <= y_d[ch];
          y2_q[ch] <= y1_q[ch];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_o      = res_q[0];
  assign right_o     = res_q[1];

endmodule

/* sv/stereo_biquad_peaking_filter_unit.sv */
// Top level of the stereo biquad peaking filter.
// Depends on sbq_pkg, sbq_cfg, sbq_front, sbq_queue and sbq_back.
//
// Usage:
//   s_axis carries one stereo frame per transfer, m_axis one filtered frame.
//   Each channel runs a direct form I biquad with shared coefficients b0, b1,
//   b2, a1, a2 (signed Q4.(COEF_WIDTH-5)); results are rounded to nearest and
//   saturated. With filter_enable clear, frames pass unchanged, history holds.
//   The cfg channel writes one register per transfer (index 0..5, see
//   cfg_reg_e); cfg_ready_o is always high. Write only while the block is idle.
//   Throughput: one frame per cycle while m_axis_tready stays high. Front:
//   products, then feedforward sum; a 4-entry queue; back: a1 feedback
//   multiply, add, round and saturate in the recursion through the output
//   history, then the output register.
//   s_axis_tready drops once queue plus front stages hold four frames, so a
//   stalled receiver backs up the input after four frames plus the output
//   register. Reset clears history to zero, b0 to 1.0, other taps to zero,
//   enables filtering and empties the pipeline.
module stereo_biquad_peaking_filter_unit #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [SW-1:0] left_in, [2*SW-1:SW] right_in, zero pad to bytes
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [SW-1:0] left_out, [2*SW-1:SW] right_out, zero pad to bytes
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sbq_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [COEF_WIDTH-1:0]                cfg_data_i
);
  import sbq_pkg::*;

  localparam int TDATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;

  logic [NUM_COEF-1:0][COEF_WIDTH-1:0] coef;
  logic                                enable;
  sbq_qstat_t                          qstat;
  sbq_item_t                           push_item, pop_item;
  logic                                push, pop;
  logic [SAMPLE_WIDTH-1:0]             left_out, right_out;

  sbq_cfg #(.COEF_WIDTH(COEF_WIDTH)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef),
    .enable_o    (enable)
  );

  sbq_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .left_i     (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .right_i    (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .coef_i     (coef),
    .enable_i   (enable),
    .qstat_i    (qstat),
    .push_o     (push),
    .item_o     (push_item)
  );

  sbq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .qstat_o (qstat)
  );

  sbq_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .item_i      (pop_item),
    .pop_o       (pop),
    .coef_i      (coef),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .left_o      (left_out),
    .right_o     (right_out)
  );

  assign m_axis_tdata = TDATA_W'({right_out, left_out});

endmodule

/* sv/sbq_checker.sv */
// Port-level checks for the stereo biquad peaking filter, bound to the top.
// Depends on stereo_biquad_peaking_filter_unit.
module sbq_checker #(
  parameter int TDATA_W = 48
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o
);

  logic       in_xfer, out_xfer;
  logic [2:0] pending_q;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {2'b0, in_xfer} - {2'b0, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output frame changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pending_q != 3'd0)
    else $error("output transfer without a pending input frame");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd5)
    else $error("more frames in flight than the pipeline holds");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind stereo_biquad_peaking_filter_unit sbq_checker #(
  .TDATA_W (((2*SAMPLE_WIDTH+7)/8)*8)
) u_sbq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);
